@@ design/maximal_square_binary_image_defines.svh @@
// Assertion macros shared by the maximal square block.
`ifndef MAXIMAL_SQUARE_BINARY_IMAGE_DEFINES_SVH
`define MAXIMAL_SQUARE_BINARY_IMAGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/msq_pkg.sv @@
`default_nettype none
package msq_pkg;

   localparam int SIDE_W      = 11;
   localparam int AREA_W      = 21;
   localparam int CFG_W       = 11;
   localparam int MAX_COLS_DEF = 1024;

   localparam logic [CFG_W-1:0]  WIDTH_RESET = 11'd1024;
   localparam logic [SIDE_W-1:0] RUN_LIMIT   = 11'd2047;

   typedef struct packed {
      logic pixel;
      logic frame_end;
   } msq_req_type;

   typedef struct packed {
      logic [SIDE_W-1:0] best_side;
      logic [AREA_W-1:0] best_area;
   } msq_rsp_type;

   // One column entry of the line store.
   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [SIDE_W-1:0] up_run;
   } msq_line_type;

   typedef struct packed {
      logic              pixel;
      logic [SIDE_W-1:0] left;
      logic [SIDE_W-1:0] up;
      logic [SIDE_W-1:0] diag;
      logic [SIDE_W-1:0] best;
   } msq_cell_in_type;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [SIDE_W-1:0] new_up;
      logic [SIDE_W-1:0] new_left;
      logic [SIDE_W-1:0] best;
   } msq_cell_out_type;

endpackage
`default_nettype wire

@@ design/msq_line_buf.sv @@
`default_nettype none
module msq_line_buf
   import msq_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic         clock,
   input  wire logic         wr_en,
   input  wire logic [CW-1:0] wr_addr,
   input  wire msq_line_type wr_data,
   input  wire logic [CW-1:0] rd_addr,
   output msq_line_type      rd_data
);

   msq_line_type mem [MAX_COLS];
   msq_line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the column being written returns the new entry (one-column rows).
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/msq_dp_cell.sv @@
`default_nettype none
module msq_dp_cell
   import msq_pkg::*;
(
   input  wire msq_cell_in_type  cell_in,
   output msq_cell_out_type      cell_out
);

   logic [SIDE_W-1:0] min_lu;
   logic [SIDE_W-1:0] min_all;
   logic [SIDE_W:0]   side_sum;
   logic [SIDE_W-1:0] side;

   always_comb begin
      min_lu   = (cell_in.left < cell_in.up) ? cell_in.left : cell_in.up;
      min_all  = (cell_in.diag < min_lu) ? cell_in.diag : min_lu;
      side_sum = {1'b0, min_all} + {{SIDE_W{1'b0}}, 1'b1};
      side     = cell_in.pixel ? side_sum[SIDE_W-1:0] : '0;

      cell_out.side = side;
      if (cell_in.pixel) begin
         cell_out.new_up   = (cell_in.up >= RUN_LIMIT) ? RUN_LIMIT
                                                       : cell_in.up + SIDE_W'(1);
         cell_out.new_left = (cell_in.left >= RUN_LIMIT) ? RUN_LIMIT
                                                         : cell_in.left + SIDE_W'(1);
      end else begin
         cell_out.new_up   = '0;
         cell_out.new_left = '0;
      end
      cell_out.best = (side > cell_in.best) ? side : cell_in.best;
   end

endmodule
`default_nettype wire

@@ design/msq_out_stage.sv @@
`default_nettype none
`include "maximal_square_binary_image_defines.svh"
module msq_out_stage
   import msq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [SIDE_W-1:0] push_side,
   output logic                   ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output msq_rsp_type            rsp_data
);

   logic              mid_valid_ff, mid_valid_in;
   logic [SIDE_W-1:0] mid_side_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   msq_rsp_type       rsp_data_ff;
   logic              out_free;
   logic [2*SIDE_W-1:0] area_full;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ready    = !mid_valid_ff || out_free;
   assign area_full = {{SIDE_W{1'b0}}, mid_side_ff} * {{SIDE_W{1'b0}}, mid_side_ff};

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (push) begin
         mid_valid_in = 1'b1;
      end else if (out_free) begin
         mid_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? mid_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mid_side_ff <= push_side;
      end
      if (out_free && mid_valid_ff) begin
         rsp_data_ff.best_side <= mid_side_ff;
         rsp_data_ff.best_area <= area_full[AREA_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MSQ_ASSERT_NEXT(a_mid_holds, clock, reset, mid_valid_ff && rsp_valid_ff && rsp_stall, mid_valid_ff)
   `MSQ_ASSERT_IMPLY(a_rsp_from_mid, clock, reset, $rose(rsp_valid_ff), $past(mid_valid_ff))

endmodule
`default_nettype wire

@@ design/maximal_square_binary_image.sv @@
// A frame's result passes through the holding register and then the output register after its last pixel is accepted.
// Throughput: one pixel per cycle while req_stall is low; the line store reads the next column's entry in advance.
// Output stage: a holding register and an output register absorb response stalls.
// Reset clears the frame state, sets the row width to 1024 and empties the output stage.
// The line store is not cleared; the first row of each frame masks its contents.
`default_nettype none
`include "maximal_square_binary_image_defines.svh"
module maximal_square_binary_image
   import msq_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msq_req_type      req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msq_rsp_type           rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data
);

   localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CMPW = (CW >= CFG_W) ? CW + 1 : CFG_W + 1;
   localparam logic [CMPW-1:0] MaxCols = CMPW'(MAX_COLS);

   logic [CFG_W-1:0]  image_width_ff;
   logic [CW-1:0]     column_index_ff, column_index_in;
   logic              first_row_ff, first_row_in;
   logic [SIDE_W-1:0] left_run_ff, left_run_in;
   logic [SIDE_W-1:0] diagonal_side_ff, diagonal_side_in;
   logic [SIDE_W-1:0] best_so_far_ff, best_so_far_in;

   logic              accept;
   logic              frame_done;
   logic              frame_clear;
   logic              out_ready;
   logic              col_zero;
   logic              wrap;
   logic [CMPW-1:0]   width_ext, eff_width, col_next;
   msq_line_type      line_rd, line_wr;
   msq_cell_in_type   cell_in;
   msq_cell_out_type  cell_out;

   assign req_stall   = !out_ready;
   assign accept      = req_valid && !req_stall;
   assign frame_done  = accept && req_data.frame_end;
   assign frame_clear = first_row_ff && (column_index_ff == '0) && (best_so_far_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         image_width_ff <= csr_write_data;
      end
   end

   always_comb begin
      width_ext = CMPW'(image_width_ff);
      if (width_ext == '0) begin
         eff_width = CMPW'(1);
      end else if (width_ext > MaxCols) begin
         eff_width = MaxCols;
      end else begin
         eff_width = width_ext;
      end
      col_next = CMPW'(column_index_ff) + CMPW'(1);
      wrap     = col_next >= eff_width;
      col_zero = column_index_ff == '0;
   end

   always_comb begin
      cell_in.pixel = req_data.pixel;
      cell_in.left  = col_zero ? '0 : left_run_ff;
      cell_in.up    = first_row_ff ? '0 : line_rd.up_run;
      cell_in.diag  = (col_zero || first_row_ff) ? '0 : diagonal_side_ff;
      cell_in.best  = best_so_far_ff;
   end

   msq_dp_cell u_cell (
      .cell_in  (cell_in),
      .cell_out (cell_out)
   );

   always_comb begin
      column_index_in  = column_index_ff;
      first_row_in     = first_row_ff;
      left_run_in      = left_run_ff;
      diagonal_side_in = diagonal_side_ff;
      best_so_far_in   = best_so_far_ff;
      if (accept) begin
         priority if (req_data.frame_end) begin
            column_index_in  = '0;
            first_row_in     = 1'b1;
            left_run_in      = '0;
            diagonal_side_in = '0;
            best_so_far_in   = '0;
         end else if (wrap) begin
            column_index_in  = '0;
            first_row_in     = 1'b0;
            left_run_in      = '0;
            diagonal_side_in = '0;
            best_so_far_in   = cell_out.best;
         end else begin
            column_index_in  = col_next[CW-1:0];
            left_run_in      = cell_out.new_left;
            diagonal_side_in = first_row_ff ? '0 : line_rd.side;
            best_so_far_in   = cell_out.best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff  <= '0;
         first_row_ff     <= 1'b1;
         left_run_ff      <= '0;
         diagonal_side_ff <= '0;
         best_so_far_ff   <= '0;
      end else begin
         column_index_ff  <= column_index_in;
         first_row_ff     <= first_row_in;
         left_run_ff      <= left_run_in;
         diagonal_side_ff <= diagonal_side_in;
         best_so_far_ff   <= best_so_far_in;
      end
   end

   assign line_wr.side   = cell_out.side;
   assign line_wr.up_run = cell_out.new_up;

   // The store is read at the column that the next pixel will use.
   msq_line_buf #(
      .MAX_COLS (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (column_index_ff),
      .wr_data (line_wr),
      .rd_addr (column_index_in),
      .rd_data (line_rd)
   );

   msq_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_done),
      .push_side (cell_out.best),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `MSQ_ASSERT_IMPLY(a_col_in_range, clock, reset, 1'b1, CMPW'(column_index_ff) < MaxCols)
   `MSQ_ASSERT_NEXT(a_frame_clears, clock, reset, frame_done, frame_clear)

endmodule
`default_nettype wire
